// File: rtl/ese_pkg.sv
// shared types and constants for the sieve engine
package ese_pkg;

    // command codes of an input item
    localparam logic CMD_SIEVE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // status codes of a result item
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    // register and field widths
    localparam int LIMIT_W  = 21;
    localparam int NUMBER_W = 20;
    localparam int STATUS_W = 2;

    // limit after reset, smallest bound used by a sieve
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'h100000;
    localparam int MIN_BOUND = 2;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_CHECK,
        S_CROSS,
        S_QUERY,
        S_FINISH
    } ese_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic clr_step;
        logic rd_i;
        logic rd_num;
        logic next_i;
        logic cross_start;
        logic cross_step;
        logic finish;
    } ese_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_sieve;
        logic clr_last;
        logic sq_done;
        logic composite;
        logic cross_last;
        logic out_free;
    } ese_stat_t;

endpackage

// File: rtl/ese_ctrl.sv
// controller state machine of the sieve engine
module ese_ctrl
    import ese_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ese_stat_t stat,
    output ese_cmd_t  cmd
);

    ese_state_t state_reg;
    ese_state_t state_next;
    logic       accept;

    assign accept = in_valid && (state_reg == S_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = stat.is_sieve ? S_CLEAR : S_QUERY;
                end
            end
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                state_next = stat.sq_done ? S_FINISH : S_CHECK;
            end
            S_CHECK:
            begin
                state_next = stat.composite ? S_SCAN : S_CROSS;
            end
            S_CROSS:
            begin
                if (stat.cross_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_QUERY:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            S_SCAN:
            begin
                cmd.rd_i = !stat.sq_done;
            end
            S_CHECK:
            begin
                cmd.next_i      = stat.composite;
                cmd.cross_start = !stat.composite;
            end
            S_CROSS:
            begin
                cmd.cross_step = 1'b1;
                cmd.next_i     = stat.cross_last;
            end
            S_QUERY:
            begin
                cmd.rd_num = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/ese_datapath.sv
// datapath of the sieve engine: composite table, counters and result register
module ese_datapath
    import ese_pkg::*;
#(
    parameter int MAX_NUMBERS = 1048576
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ese_cmd_t            cmd,
    output ese_stat_t           stat,
    input  logic                command,
    input  logic [NUMBER_W-1:0] number,
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_wdata,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                is_prime,
    output logic [STATUS_W-1:0] status
);

    localparam int AW = $clog2(MAX_NUMBERS);
    localparam int BW = $clog2(MAX_NUMBERS + 1);
    localparam int SW = BW + 1;
    localparam int CW = (BW > LIMIT_W) ? BW : LIMIT_W;

    logic                mem [MAX_NUMBERS];
    logic                rd_data_reg;

    logic [LIMIT_W-1:0]  limit_reg;
    logic                ready_reg;
    logic [BW-1:0]       bound_reg;
    logic [BW-1:0]       bound_next;
    logic                cmd_reg;
    logic [NUMBER_W-1:0] num_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [STATUS_W-1:0] st_next;
    logic [BW-1:0]       clr_reg;
    logic [BW-1:0]       i_reg;
    logic [SW-1:0]       sq_reg;
    logic [SW-1:0]       j_reg;
    logic [SW-1:0]       j_next;

    logic                out_valid_reg;
    logic                is_prime_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [CW-1:0]       lim_ext;
    logic                we;
    logic [AW-1:0]       wa;
    logic                wd;
    logic                re;
    logic [AW-1:0]       ra;

    // effective sieve bound from the limit register
    always_comb
    begin
        lim_ext = CW'(limit_reg);
        if (lim_ext < CW'(MIN_BOUND))
        begin
            bound_next = BW'(MIN_BOUND);
        end
        else if (lim_ext > CW'(MAX_NUMBERS))
        begin
            bound_next = BW'(MAX_NUMBERS);
        end
        else
        begin
            bound_next = BW'(lim_ext);
        end
    end

    // query status decided when the item is taken
    always_comb
    begin
        if (command == CMD_SIEVE)
        begin
            st_next = ST_OK;
        end
        else if (!ready_reg)
        begin
            st_next = ST_NOT_BUILT;
        end
        else if (CW'(number) >= CW'(bound_reg))
        begin
            st_next = ST_RANGE;
        end
        else
        begin
            st_next = ST_OK;
        end
    end

    // limit register and table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            ready_reg <= 1'b0;
            bound_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.accept && (command == CMD_SIEVE))
            begin
                bound_reg <= bound_next;
            end
            if (cmd.finish && (cmd_reg == CMD_SIEVE))
            begin
                ready_reg <= 1'b1;
            end
        end
    end

    // item fields and sieve counters
    assign j_next = j_reg + SW'(i_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg <= command;
            num_reg <= number;
            st_reg  <= st_next;
            clr_reg <= '0;
            i_reg   <= BW'(MIN_BOUND);
            sq_reg  <= SW'(MIN_BOUND * MIN_BOUND);
        end
        if (cmd.clr_step)
        begin
            clr_reg <= clr_reg + BW'(1);
        end
        if (cmd.next_i)
        begin
            i_reg  <= i_reg + BW'(1);
            sq_reg <= sq_reg + {i_reg, 1'b1};
        end
        if (cmd.cross_start)
        begin
            j_reg <= sq_reg;
        end
        else if (cmd.cross_step)
        begin
            j_reg <= j_next;
        end
    end

    // composite table port selection
    assign we = cmd.clr_step || cmd.cross_step;
    assign wa = cmd.clr_step ? clr_reg[AW-1:0] : j_reg[AW-1:0];
    assign wd = cmd.clr_step ? (clr_reg < BW'(MIN_BOUND)) : 1'b1;
    assign re = cmd.rd_i || cmd.rd_num;
    assign ra = cmd.rd_num ? AW'(num_reg) : i_reg[AW-1:0];

    // composite table
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg   <= st_reg;
            is_prime_reg <= (cmd_reg == CMD_QUERY) && (st_reg == ST_OK) && !rd_data_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;
    assign status    = status_reg;

    // status to the controller
    assign stat.is_sieve   = (command == CMD_SIEVE);
    assign stat.clr_last   = (clr_reg == (bound_reg - BW'(1)));
    assign stat.sq_done    = (sq_reg >= SW'(bound_reg));
    assign stat.composite  = rd_data_reg;
    assign stat.cross_last = (j_next >= SW'(bound_reg));
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

// File: rtl/eratosthenes_sieve_engine_core.sv
// query: table read in S_QUERY, result set in S_FINISH, one item at a time
// sieve: S_CLEAR, then S_SCAN and S_CHECK per candidate i with i*i below bound,
//   S_CROSS for each prime i; bound is the limit clamped to 2..MAX_NUMBERS
// the table has one write and one read port, each sieve clears [0, bound) first
// reset: controller idle, no result pending, table not built, limit 1048576
// the table itself is not cleared by reset
module eratosthenes_sieve_engine_core
    import ese_pkg::*;
#(
    parameter int MAX_NUMBERS = 1048576
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [NUMBER_W-1:0] number,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                is_prime,
    output logic [STATUS_W-1:0] status,
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_wdata
);

    ese_cmd_t  cmd;
    ese_stat_t stat;

    // sequencer
    ese_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table and counters
    ese_datapath #(
        .MAX_NUMBERS (MAX_NUMBERS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .command   (command),
        .number    (number),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_prime  (is_prime),
        .status    (status)
    );

endmodule

// File: rtl/ese_checker.sv
// port checker for the sieve engine and its bind
module ese_checker
    import ese_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic                is_prime,
    input logic [STATUS_W-1:0] status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_prime) && $stable(status))
        else $error("result changed while stalled");

    // only defined status codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_NOT_BUILT) || (status == ST_RANGE))
        else $error("undefined status code");

    // an error status never reports a prime
    a_err_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> !is_prime)
        else $error("prime flag with error status");

    // one item at a time: busy in the cycle after an item is taken
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after an item was taken");

endmodule

bind eratosthenes_sieve_engine_core ese_checker u_ese_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_prime  (is_prime),
    .status    (status)
);

// File: dv/tb_top.sv
// self-checking testbench for the sieve engine core, driven against a bit-level table model
module tb_top;
    import ese_pkg::*;

    // full-size table, limits above it exercise the clamp
    localparam int TABLE_SIZE   = 1048576;
    localparam int CYCLE_LIMIT  = 40000000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int NUMBER_MAX   = 2**NUMBER_W - 1;
    localparam logic [LIMIT_W-1:0] LIMIT_TOP = 21'h1FFFFF;

    typedef struct packed {
        logic                is_prime;
        logic [STATUS_W-1:0] status;
    } verdict_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                command;
    logic [NUMBER_W-1:0] number;
    logic                out_valid;
    logic                out_ready;
    logic                is_prime;
    logic [STATUS_W-1:0] status;
    logic                cfg_we;
    logic [LIMIT_W-1:0]  cfg_wdata;

    // table model state
    bit                  composite_tbl [TABLE_SIZE];
    bit                  table_built;
    int unsigned         sieve_bound;
    logic [LIMIT_W-1:0]  limit_reg;

    // expected verdicts in item order
    verdict_t            verdict_q [$];
    verdict_t            exp_verdict;

    int                  fail_count  = 0;
    int                  cycle_count = 0;
    int                  burst_left  = 0;
    bit                  sender_gaps = 1'b1;
    int                  stall_mode  = 0;
    int                  mode_left   = 0;

    eratosthenes_sieve_engine_core #(
        .MAX_NUMBERS (TABLE_SIZE)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .number    (number),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_prime  (is_prime),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // sieve or query against the model, returns the verdict the block must give
    function automatic verdict_t predict_item(input logic cmd, input logic [NUMBER_W-1:0] num);
        int unsigned bnd;
        int unsigned i;
        int unsigned j;
        verdict_t    v;
        v.is_prime = 1'b0;
        v.status   = ST_OK;
        if (cmd == CMD_SIEVE)
        begin
            bnd = 32'(limit_reg);
            if (bnd < MIN_BOUND)
                bnd = MIN_BOUND;
            if (bnd > TABLE_SIZE)
                bnd = TABLE_SIZE;
            for (i = 0; i < bnd; i++)
                composite_tbl[i] = 1'b0;
            composite_tbl[0] = 1'b1;
            composite_tbl[1] = 1'b1;
            for (i = 2; i * i < bnd; i++)
            begin
                if (!composite_tbl[i])
                begin
                    for (j = i * i; j < bnd; j += i)
                        composite_tbl[j] = 1'b1;
                end
            end
            sieve_bound = bnd;
            table_built = 1'b1;
        end
        else if (!table_built)
            v.status = ST_NOT_BUILT;
        else if (num >= sieve_bound)
            v.status = ST_RANGE;
        else
            v.is_prime = !composite_tbl[num];
        return v;
    endfunction

    // query number: mostly inside the bound, some at its edge, some anywhere
    function automatic logic [NUMBER_W-1:0] pick_number();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (!table_built || r < 10)
            n = $urandom_range(0, NUMBER_MAX);
        else if (r < 20)
            n = $urandom_range(0, 64);
        else if (r < 30)
            n = sieve_bound - 2 + $urandom_range(0, 3);
        else
            n = $urandom_range(0, sieve_bound - 1);
        return n[NUMBER_W-1:0];
    endfunction

    // send one item, bursts with random gaps when enabled
    task automatic send_item(input logic cmd, input logic [NUMBER_W-1:0] num);
        int gap;
        if (sender_gaps && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        command  <= cmd;
        number   <= num;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        verdict_q.push_back(predict_item(cmd, num));
    endtask

    // stop sending and let every pending verdict come back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // limit write, only with the block idle
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_all_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_reg = value;
    endtask

    // queries with no table built yet
    task automatic test_query_before_sieve();
        send_item(CMD_QUERY, '0);
        send_item(CMD_QUERY, NUMBER_W'(NUMBER_MAX));
        send_item(CMD_QUERY, 20'd7);
    endtask

    // sieve over the whole table at the reset limit
    task automatic test_full_table();
        send_item(CMD_SIEVE, NUMBER_W'(NUMBER_MAX));
        send_item(CMD_QUERY, 20'd0);
        send_item(CMD_QUERY, 20'd2);
        send_item(CMD_QUERY, 20'd4);
        send_item(CMD_QUERY, 20'd65521);
        send_item(CMD_QUERY, 20'd65535);
        send_item(CMD_QUERY, 20'd65536);
        send_item(CMD_QUERY, NUMBER_W'(NUMBER_MAX));
    endtask

    // limits of zero and one act as two; three is the smallest bound holding a prime
    task automatic test_limit_extremes();
        write_limit('0);
        send_item(CMD_SIEVE, '0);
        send_item(CMD_QUERY, 20'd0);
        send_item(CMD_QUERY, 20'd1);
        send_item(CMD_QUERY, 20'd2);
        write_limit(21'd1);
        send_item(CMD_SIEVE, '0);
        send_item(CMD_QUERY, 20'd1);
        write_limit(21'd3);
        send_item(CMD_SIEVE, '0);
        send_item(CMD_QUERY, 20'd2);
        send_item(CMD_QUERY, 20'd3);
    endtask

    // new limit has no effect on queries until the next sieve
    task automatic test_limit_change();
        write_limit(21'd100);
        send_item(CMD_QUERY, 20'd50);
        send_item(CMD_SIEVE, '0);
        send_item(CMD_QUERY, 20'd97);
        send_item(CMD_QUERY, 20'd99);
    endtask

    // phases of random limit, usually a leading sieve, then mostly queries
    task automatic test_random();
        int                 done_items;
        int                 phase;
        int                 len;
        int unsigned        r;
        logic [LIMIT_W-1:0] lim;
        done_items = 0;
        phase      = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (phase == 0)
                lim = LIMIT_TOP;
            else if (r < 5)
                lim = LIMIT_W'($urandom_range(0, 3));
            else if (r < 75)
                lim = LIMIT_W'($urandom_range(4, 512));
            else if (r < 95)
                lim = LIMIT_W'($urandom_range(513, 2048));
            else
                lim = LIMIT_W'($urandom_range(2049, 8192));
            write_limit(lim);
            sender_gaps = ($urandom_range(0, 3) != 0);
            burst_left  = 0;
            len         = $urandom_range(30, 60);
            if ($urandom_range(0, 99) < 85)
            begin
                send_item(CMD_SIEVE, NUMBER_W'($urandom_range(0, NUMBER_MAX)));
                done_items++;
            end
            repeat (len)
            begin
                // full-table phase keeps to queries, a full sieve is long
                if (phase != 0 && $urandom_range(0, 99) < 4)
                    send_item(CMD_SIEVE, NUMBER_W'($urandom_range(0, NUMBER_MAX)));
                else
                    send_item(CMD_QUERY, pick_number());
                done_items++;
            end
            phase++;
        end
        wait_all_results();
    endtask

    // result side: stall pattern and verdict check
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 400);
        end
        else
            mode_left--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= (cycle_count % 4 == 0);
        endcase
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result with no item pending: is_prime %0d status %0d", is_prime, status);
                fail_count++;
            end
            else
            begin
                exp_verdict = verdict_q.pop_front();
                if (is_prime !== exp_verdict.is_prime)
                begin
                    $error("is_prime mismatch: expected %0d, actual %0d",
                           exp_verdict.is_prime, is_prime);
                    fail_count++;
                end
                if (status !== exp_verdict.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_verdict.status, status);
                    fail_count++;
                end
            end
        end
    end

    // reset, tests in turn, final verdict
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_SIEVE;
        number      = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        out_ready   = 1'b0;
        limit_reg   = LIMIT_RESET;
        table_built = 1'b0;
        sieve_bound = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_query_before_sieve();
        test_full_table();
        test_limit_extremes();
        test_limit_change();
        test_random();
        wait_all_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
